>>> rtl/pse_pkg.sv
package pse_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int SYM_W       = 8;
	localparam int STATUS_W    = 3;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DIV_W       = DATA_W + FRAC_BITS;
	localparam int DIVCNT_W    = $clog2(DIV_W + 1);

	localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_UNDERFLOW = 3'd1;
	localparam status_t ST_OVERFLOW  = 3'd2;
	localparam status_t ST_DIVZERO   = 3'd3;
	localparam status_t ST_EMPTY     = 3'd4;
	localparam status_t ST_SATURATED = 3'd5;

	localparam logic signed [63:0] MAX64 = 64'sd2147483647;
	localparam logic signed [63:0] MIN64 = -64'sd2147483648;

	typedef enum logic [2:0] {
		SYM_DIGIT,
		SYM_ADD,
		SYM_SUB,
		SYM_MUL,
		SYM_DIV,
		SYM_OTHER
	} sym_class_t;

	typedef enum logic [1:0] {
		RES_ADDSUB,
		RES_MUL,
		RES_DIV,
		RES_ZERO
	} res_sel_t;

	typedef struct packed {
		logic     accept;
		logic     push;
		logic     underflow;
		logic     wr_result;
		res_sel_t res_sel;
		logic     mul_capture;
		logic     div_start;
		logic     emit;
	} pse_cmd_t;

	typedef struct packed {
		sym_class_t cls;
		logic       last;
		logic       cnt_lt2;
		logic       rhs_zero;
		logic       div_done;
		logic       out_free;
	} pse_stat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     sat;
	} clamp_t;

	function automatic sym_class_t classify(logic [SYM_W-1:0] s);
		sym_class_t c;
		c = SYM_OTHER;
		if (s >= CH_ZERO && s <= CH_NINE)
			c = SYM_DIGIT;
		else if (s == CH_PLUS)
			c = SYM_ADD;
		else if (s == CH_MINUS)
			c = SYM_SUB;
		else if (s == CH_STAR)
			c = SYM_MUL;
		else if (s == CH_SLASH)
			c = SYM_DIV;
		return c;
	endfunction

	function automatic clamp_t clamp32(logic signed [63:0] v);
		clamp_t r;
		r.value = v[DATA_W-1:0];
		r.sat   = 1'b0;
		if (v > MAX64) begin
			r.value = MAX64[DATA_W-1:0];
			r.sat   = 1'b1;
		end else if (v < MIN64) begin
			r.value = MIN64[DATA_W-1:0];
			r.sat   = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> rtl/pse_char_if.sv
interface pse_char_if;
	import pse_pkg::*;

	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;

	modport source(output valid, output symbol, output last, input ready);
	modport sink(input valid, input symbol, input last, output ready);

endinterface

>>> rtl/pse_result_if.sv
interface pse_result_if;
	import pse_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;
	status_t                  status;

	modport source(output valid, output value, output status, input ready);
	modport sink(input valid, input value, input status, output ready);

endinterface

>>> rtl/pse_div.sv
module pse_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pse_pkg::DIV_W-1:0]   dividend,
	input  logic [pse_pkg::DATA_W-1:0]  divisor,
	output logic                        done,
	output logic [pse_pkg::DIV_W-1:0]   quotient
);
	import pse_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DIVCNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]   rem_q;
	logic [DATA_W-1:0]   dvs_q;
	logic [DIV_W-1:0]    quo_q;

	logic [DATA_W:0]     trial;
	logic [DATA_W:0]     diff;
	logic                ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= !start && busy_q && cnt_q == DIVCNT_W'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIVCNT_W'(DIV_W);
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
			end else if (busy_q) begin
				quo_q <= {quo_q[DIV_W-2:0], ge};
				rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
				cnt_q <= cnt_q - DIVCNT_W'(1);
				if (cnt_q == DIVCNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("Divider started while a division is running.");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("Divider signaled done without running.");

endmodule

>>> rtl/pse_datapath.sv
module pse_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pse_pkg::pse_cmd_t                 cmd,
	output pse_pkg::pse_stat_t                st,
	input  logic [pse_pkg::SYM_W-1:0]         symbol,
	input  logic                              last,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic signed [pse_pkg::DATA_W-1:0] res_value,
	output pse_pkg::status_t                  res_status
);
	import pse_pkg::*;

	logic [DATA_W-1:0]        stack_mem [STACK_DEPTH];
	logic signed [DATA_W-1:0] rd_q;
	logic signed [DATA_W-1:0] tos_q;
	logic [CNT_W-1:0]         cnt_q;
	status_t                  sticky_q;
	sym_class_t               cls_q;
	logic [3:0]               digit_q;
	logic                     last_q;
	logic signed [63:0]       mul_q;
	logic                     neg_q;
	logic                     ovalid_q;
	logic signed [DATA_W-1:0] ovalue_q;
	status_t                  ostatus_q;

	logic [ADDR_W-1:0]        rd_addr;
	logic [ADDR_W-1:0]        wr_addr;
	logic                     full;
	logic                     mem_we;
	logic signed [DATA_W:0]   sum;
	logic [DATA_W-1:0]        abs_lhs;
	logic [DATA_W-1:0]        abs_rhs;
	logic                     div_done;
	logic [DIV_W-1:0]         quo;
	logic signed [DIV_W:0]    quo_s;
	clamp_t                   res;
	logic                     err_valid;
	status_t                  err_code;

	assign rd_addr = ADDR_W'(cnt_q - CNT_W'(2));
	assign wr_addr = ADDR_W'(cnt_q - CNT_W'(1));
	assign full    = cnt_q == CNT_W'(STACK_DEPTH);
	assign mem_we  = cmd.push && !full && cnt_q != '0;

	always_ff @(posedge clk) begin
		if (mem_we)
			stack_mem[wr_addr] <= tos_q;
		rd_q <= stack_mem[rd_addr];
	end

	assign abs_lhs = rd_q[DATA_W-1] ? DATA_W'(-rd_q) : rd_q;
	assign abs_rhs = tos_q[DATA_W-1] ? DATA_W'(-tos_q) : tos_q;

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (DIV_W'(abs_lhs) << FRAC_BITS),
		.divisor  (abs_rhs),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		sum   = (cls_q == SYM_SUB) ? ({rd_q[DATA_W-1], rd_q} - {tos_q[DATA_W-1], tos_q})
		                           : ({rd_q[DATA_W-1], rd_q} + {tos_q[DATA_W-1], tos_q});
		quo_s = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		case (cmd.res_sel)
			RES_ADDSUB: res = clamp32({{(63 - DATA_W){sum[DATA_W]}}, sum});
			RES_MUL:    res = clamp32(mul_q >>> FRAC_BITS);
			RES_DIV:    res = clamp32({{(63 - DIV_W){quo_s[DIV_W]}}, quo_s});
			default: begin
				res.value = '0;
				res.sat   = 1'b0;
			end
		endcase
	end

	always_comb begin
		err_valid = 1'b0;
		err_code  = ST_OK;
		if (cmd.push && full) begin
			err_valid = 1'b1;
			err_code  = ST_OVERFLOW;
		end else if (cmd.underflow) begin
			err_valid = 1'b1;
			err_code  = ST_UNDERFLOW;
		end else if (cmd.wr_result && cmd.res_sel == RES_ZERO) begin
			err_valid = 1'b1;
			err_code  = ST_DIVZERO;
		end else if (cmd.wr_result && res.sat) begin
			err_valid = 1'b1;
			err_code  = ST_SATURATED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sticky_q  <= ST_OK;
			ovalid_q  <= 1'b0;
			tos_q     <= '0;
			cls_q     <= SYM_OTHER;
			digit_q   <= '0;
			last_q    <= 1'b0;
			mul_q     <= '0;
			neg_q     <= 1'b0;
			ovalue_q  <= '0;
			ostatus_q <= ST_OK;
		end else begin
			if (cmd.accept) begin
				cls_q   <= classify(symbol);
				digit_q <= 4'(symbol - CH_ZERO);
				last_q  <= last;
			end
			if (cmd.mul_capture)
				mul_q <= 64'(rd_q) * 64'(tos_q);
			if (cmd.div_start)
				neg_q <= rd_q[DATA_W-1] ^ tos_q[DATA_W-1];
			if (err_valid && sticky_q == ST_OK)
				sticky_q <= err_code;
			if (cmd.push && !full) begin
				tos_q <= DATA_W'(digit_q) << FRAC_BITS;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.wr_result) begin
				tos_q <= res.value;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
				if (cnt_q == '0)
					ovalue_q <= '0;
				else
					ovalue_q <= tos_q;
				if (sticky_q != ST_OK)
					ostatus_q <= sticky_q;
				else if (cnt_q == '0)
					ostatus_q <= ST_EMPTY;
				else
					ostatus_q <= ST_OK;
				cnt_q    <= '0;
				sticky_q <= ST_OK;
			end else if (res_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign st.cls      = cls_q;
	assign st.last     = last_q;
	assign st.cnt_lt2  = cnt_q < CNT_W'(2);
	assign st.rhs_zero = tos_q == '0;
	assign st.div_done = div_done;
	assign st.out_free = !ovalid_q || res_ready;

	assign res_valid  = ovalid_q;
	assign res_value  = ovalue_q;
	assign res_status = ostatus_q;

endmodule

>>> rtl/pse_ctrl.sv
module pse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pse_pkg::pse_stat_t st,
	output pse_pkg::pse_cmd_t  cmd
);
	import pse_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t after_op;

	assign in_ready = state_q == S_IDLE;
	assign after_op = st.last ? S_EMIT : S_IDLE;

	always_comb begin
		cmd         = '0;
		cmd.res_sel = RES_ADDSUB;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = after_op;
				case (st.cls)
					SYM_DIGIT: cmd.push = 1'b1;
					SYM_ADD, SYM_SUB: begin
						if (st.cnt_lt2)
							cmd.underflow = 1'b1;
						else
							cmd.wr_result = 1'b1;
					end
					SYM_MUL: begin
						if (st.cnt_lt2) begin
							cmd.underflow = 1'b1;
						end else begin
							cmd.mul_capture = 1'b1;
							state_d         = S_MUL;
						end
					end
					SYM_DIV: begin
						if (st.cnt_lt2) begin
							cmd.underflow = 1'b1;
						end else if (st.rhs_zero) begin
							cmd.wr_result = 1'b1;
							cmd.res_sel   = RES_ZERO;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
					default: ;
				endcase
			end
			S_MUL: begin
				cmd.wr_result = 1'b1;
				cmd.res_sel   = RES_MUL;
				state_d       = after_op;
			end
			S_DIV: begin
				cmd.res_sel = RES_DIV;
				if (st.div_done) begin
					cmd.wr_result = 1'b1;
					state_d       = after_op;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_EXEC)
		else $error("Accepted beat was not followed by execution.");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("Result emitted while the output register was occupied.");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> state_q == S_DIV)
		else $error("Divider finished outside the divide state.");

endmodule

>>> rtl/postfix_stack_evaluator.sv
// Channel   Role    Payload          Beat
// chars     sink    symbol, last     one character of the expression
// results   source  value, status    top of stack after a beat with last set
//
// Digits, ignored characters, add and subtract finish in S_EXEC; multiply also passes S_MUL.
// Divide waits in S_DIV for the one-bit-per-cycle divider (Q16.16) unless the divisor is zero.
// A beat with last set then passes S_EMIT to load the result register.
// Reset clears the count, the error and the result register; the stack needs no clearing pass.
// A stalled result holds only the next last beat, and the next beat may enter meanwhile.
module postfix_stack_evaluator (
	input logic         clk,
	input logic         arst_n,
	pse_char_if.sink    chars,
	pse_result_if.source results
);
	import pse_pkg::*;

	pse_cmd_t  cmd;
	pse_stat_t st;

	pse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.st       (st),
		.cmd      (cmd)
	);

	pse_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.symbol     (chars.symbol),
		.last       (chars.last),
		.res_valid  (results.valid),
		.res_ready  (results.ready),
		.res_value  (results.value),
		.res_status (results.status)
	);

endmodule

>>> verif/tb_postfix_stack_evaluator.sv
module tb_postfix_stack_evaluator;
	timeunit 1ns;
	timeprecision 1ps;

	import pse_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		status_t                  status;
	} eval_result_t;

	logic clk;
	logic arst_n;

	pse_char_if   chars();
	pse_result_if results();

	postfix_stack_evaluator dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.results(results)
	);

	logic signed [DATA_W-1:0] operand_mem [STACK_DEPTH];
	int                       operand_depth = 0;
	status_t                  first_fault = ST_OK;
	eval_result_t             pending_results[$];

	int fault_count;
	int cycle_count;
	int chars_sent;
	int gap_pct;
	int stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void note_fault(status_t code);
		if (first_fault == ST_OK)
			first_fault = code;
	endfunction

	function automatic logic signed [DATA_W-1:0] saturate(logic signed [63:0] v);
		if (v > MAX64) begin
			note_fault(ST_SATURATED);
			return MAX64[DATA_W-1:0];
		end
		if (v < MIN64) begin
			note_fault(ST_SATURATED);
			return MIN64[DATA_W-1:0];
		end
		return v[DATA_W-1:0];
	endfunction

	function automatic void evaluate_char(logic [SYM_W-1:0] sym, logic lst);
		logic signed [63:0] lhs;
		logic signed [63:0] rhs;
		logic signed [63:0] acc;
		eval_result_t       res;
		if (sym >= CH_ZERO && sym <= CH_NINE) begin
			if (operand_depth >= STACK_DEPTH) begin
				note_fault(ST_OVERFLOW);
			end else begin
				operand_mem[ADDR_W'(operand_depth)] = DATA_W'(sym - CH_ZERO) << FRAC_BITS;
				operand_depth++;
			end
		end else if (sym inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
			if (operand_depth < 2) begin
				note_fault(ST_UNDERFLOW);
			end else begin
				rhs = operand_mem[ADDR_W'(operand_depth - 1)];
				lhs = operand_mem[ADDR_W'(operand_depth - 2)];
				operand_depth -= 2;
				case (sym)
					CH_PLUS: acc = lhs + rhs;
					CH_MINUS: acc = lhs - rhs;
					CH_STAR: acc = (lhs * rhs) >>> FRAC_BITS;
					default: begin
						if (rhs == 0) begin
							note_fault(ST_DIVZERO);
							acc = 0;
						end else begin
							acc = (lhs <<< FRAC_BITS) / rhs;
						end
					end
				endcase
				operand_mem[ADDR_W'(operand_depth)] = saturate(acc);
				operand_depth++;
			end
		end
		if (lst) begin
			res.value  = '0;
			res.status = ST_EMPTY;
			if (operand_depth > 0) begin
				res.value  = operand_mem[ADDR_W'(operand_depth - 1)];
				res.status = ST_OK;
			end
			if (first_fault != ST_OK)
				res.status = first_fault;
			pending_results.push_back(res);
			operand_depth = 0;
			first_fault   = ST_OK;
		end
	endfunction

	// Results are checked before the beat of the same edge is predicted.
	always @(posedge clk) begin
		eval_result_t want;
		if (arst_n) begin
			if (results.valid && results.ready) begin
				if (pending_results.size() == 0) begin
					fault_count++;
					$display("%0t: no result expected, got value %0d status %0d",
						$time, results.value, results.status);
				end else begin
					want = pending_results.pop_front();
					if (results.value !== want.value) begin
						fault_count++;
						$display("%0t: value expected %0d got %0d",
							$time, want.value, results.value);
					end
					if (results.status !== want.status) begin
						fault_count++;
						$display("%0t: status expected %0d got %0d",
							$time, want.status, results.status);
					end
				end
			end
			if (chars.valid && chars.ready)
				evaluate_char(chars.symbol, chars.last);
		end
	end

	always @(posedge clk) begin
		results.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("postfix_stack_evaluator: mismatch");
			$finish;
		end
	end

	task automatic send_char(input logic [SYM_W-1:0] sym, input logic lst);
		while ($urandom_range(99) < gap_pct) begin
			chars.valid <= 1'b0;
			@(posedge clk);
		end
		chars.valid  <= 1'b1;
		chars.symbol <= sym;
		chars.last   <= lst;
		@(posedge clk);
		while (!chars.ready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_expression(input logic [SYM_W-1:0] expr[$]);
		for (int i = 0; i < expr.size(); i++)
			send_char(expr[i], i == expr.size() - 1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [SYM_W-1:0] random_digit();
		return CH_ZERO + SYM_W'($urandom_range(9));
	endfunction

	function automatic logic [SYM_W-1:0] random_op();
		case ($urandom_range(3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	function automatic logic [SYM_W-1:0] random_noise();
		logic [SYM_W-1:0] s;
		s = SYM_W'($urandom_range(255));
		while ((s >= CH_ZERO && s <= CH_NINE) || s inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH})
			s = SYM_W'($urandom_range(255));
		return s;
	endfunction

	task automatic set_idling(input int gap, input int stall);
		gap_pct   = gap;
		stall_pct = stall;
	endtask

	task automatic test_arithmetic();
		send_text("9");
		send_text("0");
		send_text("72-3*4/1+");
	endtask

	task automatic test_ignored_symbols();
		send_char('0, 1'b1);
		send_char('1, 1'b1);
		send_text("5a");
	endtask

	task automatic test_error_codes();
		send_text("+");
		send_text("50/+");
		send_text("99*99**9*");
		send_text("09-99*99***");
	endtask

	task automatic test_stack_limits();
		logic [SYM_W-1:0] expr[$];
		repeat (STACK_DEPTH) expr.push_back(random_digit());
		repeat (STACK_DEPTH - 1) expr.push_back(CH_PLUS);
		send_expression(expr);
		expr.delete();
		repeat (STACK_DEPTH + 1) expr.push_back(random_digit());
		send_expression(expr);
	endtask

	// Most expressions are well formed so that the arithmetic gets exercised;
	// the rest are unbalanced mixes and raw bytes.
	task automatic test_random_expressions(input int item_target);
		logic [SYM_W-1:0] expr[$];
		int               stop_at;
		int               operands;
		int               depth;
		int               push_bias;
		int               kind;
		stop_at = chars_sent + item_target;
		while (chars_sent < stop_at) begin
			expr.delete();
			kind = $urandom_range(99);
			if (kind < 75) begin
				if ($urandom_range(9) == 0) begin
					operands  = $urandom_range(20, 70);
					push_bias = 90;
				end else begin
					operands  = $urandom_range(1, 8);
					push_bias = 50;
				end
				depth = 0;
				while (operands > 0 || depth > 1) begin
					if ($urandom_range(19) == 0)
						expr.push_back(random_noise());
					if (operands > 0 && (depth < 2 || $urandom_range(99) < push_bias)) begin
						expr.push_back(random_digit());
						operands--;
						depth++;
					end else begin
						expr.push_back(random_op());
						depth--;
					end
				end
				if ($urandom_range(9) == 0)
					expr.push_back(random_noise());
			end else if (kind < 90) begin
				repeat ($urandom_range(1, 12))
					expr.push_back(($urandom_range(2) == 0) ? random_op() : random_digit());
			end else begin
				repeat ($urandom_range(1, 6))
					expr.push_back(SYM_W'($urandom_range(255)));
			end
			send_expression(expr);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		chars.valid   = 1'b0;
		chars.symbol  = '0;
		chars.last    = 1'b0;
		set_idling(0, 0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_arithmetic();
		test_ignored_symbols();
		test_error_codes();
		test_stack_limits();
		test_random_expressions(250);
		set_idling(71, 0);
		test_random_expressions(260);
		set_idling(0, 71);
		test_random_expressions(260);
		set_idling(17, 17);
		test_random_expressions(250);
		chars.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && pending_results.size() == 0)
			$display("postfix_stack_evaluator: match");
		else
			$display("postfix_stack_evaluator: mismatch");
		$finish;
	end

endmodule
